// File: src/decay_energy_constraint_defines.svh
// Assertion macros for the decay energy constraint block.
// Included by dec_back, which checks its own logic; no other dependency.
`ifndef DECAY_ENERGY_CONSTRAINT_DEFINES_SVH
`define DECAY_ENERGY_CONSTRAINT_DEFINES_SVH
`ifndef SYNTHESIS
`define DEC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DEC_NEVER(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(prop)) else $error(msg);
`else
`define DEC_ASSERT(label, clk, rst, prop, msg)
`define DEC_NEVER(label, clk, rst, prop, msg)
`endif
`endif

// File: src/dec_pkg.sv
// Shared types and constants for the decay energy constraint block.
// No dependencies; used by every module of the block.
package dec_pkg;

  localparam int MOM_W         = 26;
  localparam int MASS_W        = 18;
  localparam int EN_W          = 26;
  localparam int SUM_W         = 2 * MOM_W;
  localparam int RES_W         = 28;
  localparam int GRAD_W        = 32;
  localparam int Q_FRAC        = 30;
  localparam int MAX_PARTICLES = 8;
  localparam int POS_W         = $clog2(MAX_PARTICLES);
  localparam int CFG_W         = 18;
  localparam int CFG_IDX_W     = 2;
  localparam int CNT_W         = 5;

  localparam logic [MASS_W-1:0] KAON_MASS_RST = MASS_W'(126381);
  localparam logic [MASS_W-1:0] PION_MASS_RST = MASS_W'(35730);

  typedef enum logic [1:0] {
    MODE_K2PI       = 2'd0,
    MODE_K2PI_GAMMA = 2'd1,
    MODE_K3PI       = 2'd2,
    MODE_INVALID    = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECAY_MODE = 2'd0,
    CFG_KAON_MASS  = 2'd1,
    CFG_PION_MASS  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_DIVIDE,
    ST_DONE
  } back_state_t;

  // One classified particle on its way from the front to the back.
  typedef struct packed {
    logic [2:0][MOM_W-1:0] mag;
    logic [2:0]            neg;
    logic [MASS_W-1:0]     mass;
    logic                  no_mass;
    logic                  parent;
    logic                  last;
  } entry_t;

endpackage

// File: src/dec_front.sv
// Front end: accepts particles, tracks position within the decay, picks the mass.
// Depends on dec_pkg.
module dec_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dec_pkg::MOM_W-1:0]     mom_x,
  input  logic [dec_pkg::MOM_W-1:0]     mom_y,
  input  logic [dec_pkg::MOM_W-1:0]     mom_z,
  input  logic                          last_particle,
  input  dec_pkg::mode_t                decay_mode,
  input  logic [dec_pkg::MASS_W-1:0]    kaon_mass,
  input  logic [dec_pkg::MASS_W-1:0]    pion_mass,
  input  logic                          fifo_full,
  output logic                          push,
  output dec_pkg::entry_t               entry
);

  logic [dec_pkg::POS_W-1:0] position;
  logic [dec_pkg::MOM_W-1:0] mom [3];
  logic [dec_pkg::MASS_W-1:0] mass;
  logic                       none;

  assign in_stall = fifo_full;
  assign push     = in_valid && !fifo_full;
  assign mom[0]   = mom_x;
  assign mom[1]   = mom_y;
  assign mom[2]   = mom_z;

  always_comb begin
    mass = '0;
    none = 1'b0;
    unique case (decay_mode)
      dec_pkg::MODE_K2PI: begin
        if (position == 0) mass = kaon_mass;
        else if (position == 1) mass = pion_mass;
        else if (position > 3) none = 1'b1;
      end
      dec_pkg::MODE_K2PI_GAMMA: begin
        if (position == 0) mass = kaon_mass;
        else if (position == 1) mass = pion_mass;
        else if (position > 4) none = 1'b1;
      end
      dec_pkg::MODE_K3PI: begin
        if (position == 0) mass = kaon_mass;
        else if (position <= 3) mass = pion_mass;
        else none = 1'b1;
      end
      default: none = 1'b1;
    endcase
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      entry.neg[i] = mom[i][dec_pkg::MOM_W-1];
      entry.mag[i] = mom[i][dec_pkg::MOM_W-1] ? (~mom[i] + 1'b1) : mom[i];
    end
    entry.mass    = mass;
    entry.no_mass = none;
    entry.parent  = (position == 0);
    entry.last    = last_particle;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position <= '0;
    end else if (push) begin
      if (last_particle) position <= '0;
      else if (position < dec_pkg::POS_W'(dec_pkg::MAX_PARTICLES - 1))
        position <= position + 1'b1;
    end
  end

endmodule

// File: src/dec_fifo.sv
// Two-entry queue between the front and back ends.
// Depends on dec_pkg for the entry type.
module dec_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dec_pkg::entry_t wdata,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output dec_pkg::entry_t rdata
);

  dec_pkg::entry_t slots [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign rdata     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// File: src/dec_back.sv
// Back end: squares, integer square root, three divisions, residual update.
// Depends on dec_pkg and the assertion macros header.
`include "decay_energy_constraint_defines.svh"
module dec_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              entry_valid,
  input  dec_pkg::entry_t                   entry,
  output logic                              pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dec_pkg::EN_W-1:0]          energy,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_x,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_y,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_z,
  output logic signed [dec_pkg::RES_W-1:0]  residual,
  output logic                              no_mass,
  output logic                              last_out
);

  dec_pkg::back_state_t state, state_next;
  dec_pkg::entry_t      cur;
  logic [dec_pkg::CNT_W-1:0] cnt;
  logic [dec_pkg::SUM_W-1:0] prod, acc, rad;
  logic [dec_pkg::EN_W+1:0]  rem_s;
  logic [dec_pkg::EN_W-1:0]  root;
  logic [dec_pkg::EN_W:0]    rem_d [3];
  logic [dec_pkg::Q_FRAC:0]  quo [3];
  logic signed [dec_pkg::RES_W-1:0] balance;
  logic                      load_out;

  logic [dec_pkg::MOM_W-1:0]  sq_sel;
  logic [dec_pkg::EN_W+3:0]   rem_t, trial;
  logic [dec_pkg::EN_W:0]     div_t [3];
  logic signed [dec_pkg::RES_W:0] diff;
  logic signed [dec_pkg::RES_W-1:0] bal;
  logic [dec_pkg::GRAD_W-1:0] grad [3];

  always_ff @(posedge clk) begin
    if (rst) state <= dec_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      dec_pkg::ST_IDLE: begin
        if (entry_valid) begin
          pop        = 1'b1;
          state_next = dec_pkg::ST_SQUARE;
        end
      end
      dec_pkg::ST_SQUARE: if (cnt == 4) state_next = dec_pkg::ST_ROOT;
      dec_pkg::ST_ROOT:   if (cnt == dec_pkg::CNT_W'(dec_pkg::EN_W - 1))
        state_next = dec_pkg::ST_DIVIDE;
      dec_pkg::ST_DIVIDE: if (cnt == dec_pkg::CNT_W'(dec_pkg::Q_FRAC))
        state_next = dec_pkg::ST_DONE;
      dec_pkg::ST_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = dec_pkg::ST_IDLE;
        end
      end
      default: state_next = dec_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    case (cnt[1:0])
      2'd0:    sq_sel = cur.mag[0];
      2'd1:    sq_sel = cur.mag[1];
      2'd2:    sq_sel = cur.mag[2];
      default: sq_sel = {{(dec_pkg::MOM_W - dec_pkg::MASS_W){1'b0}}, cur.mass};
    endcase
    rem_t = {rem_s, rad[dec_pkg::SUM_W-1 -: 2]};
    trial = {2'b00, root, 2'b01};
    for (int i = 0; i < 3; i++) div_t[i] = {rem_d[i][dec_pkg::EN_W-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    unique case (state)
      dec_pkg::ST_IDLE: begin
        cur <= entry;
        cnt <= '0;
        acc <= '0;
      end
      dec_pkg::ST_SQUARE: begin
        prod <= sq_sel * sq_sel;
        acc  <= acc + ((cnt == 0) ? '0 : prod);
        cnt  <= cnt + 1'b1;
        if (cnt == 4) begin
          rad   <= acc + prod;
          rem_s <= '0;
          root  <= '0;
          cnt   <= '0;
        end
      end
      dec_pkg::ST_ROOT: begin
        // take two radicand bits per step
        rad <= rad << 2;
        if (rem_t >= trial) begin
          rem_s <= dec_pkg::EN_W'(0) + (dec_pkg::EN_W+2)'(rem_t - trial);
          root  <= {root[dec_pkg::EN_W-2:0], 1'b1};
        end else begin
          rem_s <= rem_t[dec_pkg::EN_W+1:0];
          root  <= {root[dec_pkg::EN_W-2:0], 1'b0};
        end
        cnt <= (cnt == dec_pkg::CNT_W'(dec_pkg::EN_W - 1)) ? '0 : cnt + 1'b1;
      end
      dec_pkg::ST_DIVIDE: begin
        for (int i = 0; i < 3; i++) begin
          if (cnt == 0) begin
            // integer bit: magnitude never exceeds the energy
            if (cur.mag[i] >= root) begin
              rem_d[i] <= {1'b0, cur.mag[i] - root};
              quo[i]   <= (dec_pkg::Q_FRAC+1)'(1);
            end else begin
              rem_d[i] <= {1'b0, cur.mag[i]};
              quo[i]   <= '0;
            end
          end else if (div_t[i] >= {1'b0, root}) begin
            rem_d[i] <= div_t[i] - {1'b0, root};
            quo[i]   <= {quo[i][dec_pkg::Q_FRAC-1:0], 1'b1};
          end else begin
            rem_d[i] <= div_t[i];
            quo[i]   <= {quo[i][dec_pkg::Q_FRAC-1:0], 1'b0};
          end
        end
        cnt <= cnt + 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    diff = $signed({balance[dec_pkg::RES_W-1], balance})
         - $signed({3'b000, root});
    if (cur.parent) bal = $signed({2'b00, root});
    else if (diff < -$signed((dec_pkg::RES_W+1)'(1) <<< (dec_pkg::RES_W - 1)))
      bal = {1'b1, {(dec_pkg::RES_W-1){1'b0}}};
    else bal = diff[dec_pkg::RES_W-1:0];
    for (int i = 0; i < 3; i++) begin
      if (root == 0) grad[i] = '0;
      else if (cur.neg[i] ^ ~cur.parent)
        grad[i] = ~{1'b0, quo[i]} + 1'b1;
      else grad[i] = {1'b0, quo[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      balance   <= '0;
    end else if (load_out) begin
      out_valid <= 1'b1;
      balance   <= cur.last ? '0 : bal;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      energy   <= root;
      grad_x   <= grad[0];
      grad_y   <= grad[1];
      grad_z   <= grad[2];
      residual <= bal;
      no_mass  <= cur.no_mass;
      last_out <= cur.last;
    end
  end

  `DEC_ASSERT(a_pop_idle, clk, rst, pop |-> state == dec_pkg::ST_IDLE, "pop outside idle")
  `DEC_ASSERT(a_div_rem, clk, rst,
    (state == dec_pkg::ST_DIVIDE && cnt != 0) |-> rem_d[0] < {1'b0, root} || root == 0,
    "division remainder not below divisor")
  `DEC_NEVER(a_load_stalled, clk, rst, load_out && out_valid && out_stall,
    "result overwritten while stalled")

endmodule

// File: src/decay_energy_constraint.sv
// Decay energy balance constraint. The back end handles one particle at a time
// and takes no new one from the queue until the last is through. It takes the
// item from the queue, forms the squares on one 26x26 multiplier, runs the
// two-bit-per-step square root, then the three bit-serial divisions side by
// side, and loads the result. A two-entry queue lets the front accept while the
// back works; a stalled result holds the back end until it is taken.
// Depends on dec_pkg, dec_front, dec_fifo and dec_back.
module decay_energy_constraint (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [dec_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [dec_pkg::CFG_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [dec_pkg::MOM_W-1:0]  mom_x,
  input  logic signed [dec_pkg::MOM_W-1:0]  mom_y,
  input  logic signed [dec_pkg::MOM_W-1:0]  mom_z,
  input  logic                              last_particle,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dec_pkg::EN_W-1:0]          energy,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_x,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_y,
  output logic signed [dec_pkg::GRAD_W-1:0] grad_z,
  output logic signed [dec_pkg::RES_W-1:0]  residual,
  output logic                              no_mass,
  output logic                              last_out
);

  dec_pkg::mode_t             decay_mode;
  logic [dec_pkg::MASS_W-1:0] kaon_mass;
  logic [dec_pkg::MASS_W-1:0] pion_mass;
  logic                       push, full, pop, not_empty;
  dec_pkg::entry_t            wentry, rentry;

  always_ff @(posedge clk) begin
    if (rst) begin
      decay_mode <= dec_pkg::MODE_K2PI;
      kaon_mass  <= dec_pkg::KAON_MASS_RST;
      pion_mass  <= dec_pkg::PION_MASS_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        dec_pkg::CFG_DECAY_MODE: decay_mode <= dec_pkg::mode_t'(cfg_data[1:0]);
        dec_pkg::CFG_KAON_MASS:  kaon_mass  <= cfg_data[dec_pkg::MASS_W-1:0];
        dec_pkg::CFG_PION_MASS:  pion_mass  <= cfg_data[dec_pkg::MASS_W-1:0];
        default: ;
      endcase
    end
  end

  dec_front u_front (
    .clk, .rst, .in_valid, .in_stall,
    .mom_x(mom_x), .mom_y(mom_y), .mom_z(mom_z), .last_particle,
    .decay_mode, .kaon_mass, .pion_mass,
    .fifo_full(full), .push, .entry(wentry)
  );

  dec_fifo u_fifo (
    .clk, .rst, .push, .wdata(wentry), .full,
    .pop, .not_empty, .rdata(rentry)
  );

  dec_back u_back (
    .clk, .rst, .entry_valid(not_empty), .entry(rentry), .pop,
    .out_valid, .out_stall, .energy, .grad_x, .grad_y, .grad_z,
    .residual, .no_mass, .last_out
  );

endmodule
